@@ hdl/sis_pkg.sv @@
// ============================================================================
// sis_pkg
// Shared types and codes for the sorted identifier set: request and result
// beats, status codes and the sequencer states.
// ============================================================================
`default_nettype none

package sis_pkg;

    // Request kinds carried in a request beat.
    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_READ   = 2'd3
    } req_type_t;

    // Status codes reported in a result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // One request beat.
    typedef struct packed {
        req_type_t          req_type;
        logic signed [31:0] item_id;
        logic [5:0]         read_index;
    } sis_req_t;

    // One result beat.
    typedef struct packed {
        logic               was_present;
        status_t            status;
        logic [6:0]         member_count;
        logic signed [31:0] read_value;
    } sis_rsp_t;

    // Sequencer states of the search and shift engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SEARCH_CMP,
        S_CHECK,
        S_ACT,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DRAIN,
        S_INSERT,
        S_SHRINK,
        S_READ_DATA,
        S_DONE
    } sis_state_t;

endpackage

`default_nettype wire

@@ hdl/sorted_id_set.sv @@
// ============================================================================
// sorted_id_set
// Set of distinct signed 32-bit identifiers kept in ascending order, with
// find, add, remove and read-by-index requests.
// ============================================================================
// One request beat is taken at a time and yields one result beat. The pace
// is bounded by the single read port of the entry store. A read by index
// reads the addressed entry and registers it as the result. Find, add and
// remove run a binary search of S steps, S being at most
// ceil(log2(count + 1)), then a membership read unless the key lies above
// every member. An add or remove that changes the set then moves the
// entries behind the position one per cycle. The result sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module sorted_id_set
    import sis_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sis_req_t s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sis_rsp_t      m_rsp
);

    logic     eng_valid;
    logic     eng_ready;
    sis_rsp_t eng_rsp;
    logic     m_valid_reg, m_valid_next;
    sis_rsp_t m_rsp_reg, m_rsp_next;

    sis_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_valid),
        .req_ready(s_ready),
        .req      (s_req),
        .rsp_valid(eng_valid),
        .rsp_ready(eng_ready),
        .rsp      (eng_rsp)
    );

    // Output register: loads when empty or being emptied this cycle.
    assign eng_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (eng_valid && eng_ready) begin
            m_valid_next = 1'b1;
            m_rsp_next   = eng_rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire

@@ hdl/sis_ram.sv @@
// ============================================================================
// sis_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/sis_engine.sv @@
// ============================================================================
// sis_engine
// Sequencer for the sorted identifier set. A signed less-than comparator
// works the binary search and an equality compare the membership test, and
// the entry store is moved one entry per cycle to open or close a gap.
// ============================================================================
`default_nettype none

module sis_engine
    import sis_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire sis_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output sis_rsp_t      rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    sis_state_t       state_reg, state_next;
    sis_req_t         req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] wr_addr_reg, wr_addr_next;
    logic             pend_reg, pend_next;
    logic             present_reg, present_next;
    status_t          status_reg, status_next;
    logic [31:0]      value_reg, value_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;

    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] pos_inc;
    logic             key_lt;
    logic             key_eq;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CNT_W+6:0] cnt_wide;

    sis_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Index arithmetic and the comparators against the request key.
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_inc   = ptr_reg + ONE_CNT;
    assign ptr_dec   = ptr_reg - ONE_CNT;
    assign count_dec = count_reg - ONE_CNT;
    assign pos_inc   = lo_reg + ONE_CNT;
    assign key_lt    = $signed(ram_rdata) < $signed(req_reg.item_id);
    assign key_eq    = ram_rdata == req_reg.item_id;
    assign idx_ext   = CMP_W'(req_reg.read_index);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign cnt_wide  = {7'd0, count_reg};

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
    end

    // Sequencer: next state, store accesses and result fields.
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        present_next = present_reg;
        status_next  = status_reg;
        value_next   = value_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next     = req;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    present_next = 1'b0;
                    status_next  = ST_OK;
                    value_next   = '0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (req_reg.req_type == REQ_READ) begin
                    if (idx_ext < cnt_cmp) begin
                        ram_raddr  = idx_ext[IDX_W-1:0];
                        state_next = S_READ_DATA;
                    end else begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // One halving step per visit while the range is open; the read lands next cycle.
                if (lo_reg < hi_reg) begin
                    ram_raddr  = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = S_SEARCH_CMP;
                end else if (lo_reg < count_reg) begin
                    ram_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_CHECK;
                end else begin
                    state_next = S_ACT;
                end
            end
            S_SEARCH_CMP: begin
                if (key_lt) begin
                    lo_next = mid_reg + ONE_CNT;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK: begin
                present_next = key_eq;
                state_next   = S_ACT;
            end
            S_ACT: begin
                case (req_reg.req_type)
                    REQ_ADD: begin
                        if (present_reg) begin
                            state_next = S_DONE;
                        end else if (count_reg >= CAP_CNT) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (count_reg > lo_reg) begin
                            ptr_next   = count_dec;
                            state_next = S_SHIFT_UP;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!present_reg) begin
                            state_next = S_DONE;
                        end else if (pos_inc < count_reg) begin
                            ptr_next   = pos_inc;
                            state_next = S_SHIFT_DN;
                        end else begin
                            state_next = S_SHRINK;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // Read an entry while the one read last cycle moves up.
                ram_we       = pend_reg;
                pend_next    = 1'b1;
                wr_addr_next = ptr_inc[IDX_W-1:0];
                if (ptr_reg == lo_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    ptr_next = ptr_dec;
                end
            end
            S_SHIFT_DN: begin
                // Read an entry while the one read last cycle moves down.
                ram_we       = pend_reg;
                pend_next    = 1'b1;
                wr_addr_next = ptr_dec[IDX_W-1:0];
                if (ptr_reg == count_dec) begin
                    state_next = S_DRAIN;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            S_DRAIN: begin
                ram_we    = 1'b1;
                pend_next = 1'b0;
                if (req_reg.req_type == REQ_ADD) begin
                    state_next = S_INSERT;
                end else begin
                    state_next = S_SHRINK;
                end
            end
            S_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg[IDX_W-1:0];
                ram_wdata  = req_reg.item_id;
                count_next = count_reg + ONE_CNT;
                state_next = S_DONE;
            end
            S_SHRINK: begin
                count_next = count_dec;
                state_next = S_DONE;
            end
            S_READ_DATA: begin
                value_next = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and result beat.
    assign req_ready        = state_reg == S_IDLE;
    assign rsp_valid        = state_reg == S_DONE;
    assign rsp.was_present  = present_reg;
    assign rsp.status       = status_reg;
    assign rsp.member_count = cnt_wide[6:0];
    assign rsp.read_value   = value_reg;

endmodule

`default_nettype wire

@@ hdl/sis_checker.sv @@
// ============================================================================
// sis_checker
// Port-level checks on the sorted identifier set, bound to the top level.
// ============================================================================
`default_nettype none

module sis_checker
    import sis_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire sis_rsp_t m_rsp
);

    // A stalled result beat holds its contents.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("result beat changed while stalled");

    // Only one request is in work: ready drops right after a request beat.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // A refused add reports an absent identifier and no read data.
    a_full_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == ST_FULL) |->
            !m_rsp.was_present && (m_rsp.read_value == 32'sd0))
        else $error("full status with stray fields");

    // An out-of-range read returns zero and no membership flag.
    a_range_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == ST_RANGE) |->
            !m_rsp.was_present && (m_rsp.read_value == 32'sd0))
        else $error("range status with stray fields");

endmodule

bind sorted_id_set sis_checker u_sis_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_rsp  (m_rsp)
);

`default_nettype wire
